/* rtl/core/pvtss_pkg.sv */
// ----------------------------------------------------------------------------
// pvtss_pkg
// shared types and constants of the trajectory segment subdivider
// ----------------------------------------------------------------------------
package pvtss_pkg;

  localparam int unsigned AxesDef     = 3;
  localparam int unsigned PosWidthDef = 32;
  localparam int unsigned MaxAxes     = 3;
  localparam int unsigned TimeWidth   = 8;
  // quotient of an 8-bit time by a chunk of at least 4 stays below 64
  localparam int unsigned QWidth      = 6;

  localparam logic [TimeWidth-1:0] ChunkReset = 8'd20;
  localparam logic [TimeWidth-1:0] ChunkMin   = 8'd4;

  // per-item commands from the sequencer to the axis lanes
  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

  // duration shown for an emitted point
  function automatic logic [TimeWidth-1:0] out_time_of(logic [TimeWidth-1:0] t,
                                                        logic [TimeWidth-1:0] c);
    logic [TimeWidth-1:0] r;
    r = ((t == '0) || (t >= c)) ? c : t;
    return r;
  endfunction

endpackage

/* rtl/core/pvtss_lane.sv */
// ----------------------------------------------------------------------------
// pvtss_lane
// one axis: divides the segment difference once, then steps the offset
// ----------------------------------------------------------------------------
module pvtss_lane #(
  parameter int unsigned PosWidth = pvtss_pkg::PosWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pvtss_pkg::lane_ctrl_t          ctrl_i,
  input  logic [pvtss_pkg::QWidth-1:0]   divisor_i,
  input  logic signed [PosWidth-1:0]     held_i,
  input  logic signed [PosWidth-1:0]     new_i,
  output logic signed [PosWidth-1:0]     pos_o,
  output logic                           busy_o
);
  import pvtss_pkg::*;

  localparam int unsigned DW = PosWidth + 1;
  localparam int unsigned CW = $clog2(DW + 1);

  logic signed [DW:0]   diff;
  logic [DW:0]          mag_full;
  logic [DW-1:0]        quo_q, quo_d, acc_q, acc_d;
  logic [QWidth-1:0]    rem_q, rem_d, racc_q, racc_d;
  logic [QWidth:0]      trial, rsum;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d, neg_q, neg_d;
  logic signed [DW:0]   offset, sum;

  // signed difference and its magnitude
  assign diff     = (DW+1)'(new_i) - (DW+1)'(held_i);
  assign mag_full = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
  assign trial    = {rem_q, quo_q[DW-1]};
  assign rsum     = {1'b0, racc_q} + {1'b0, rem_q};

  // restoring division one bit a cycle, then one offset step per point
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    racc_d = racc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    if (ctrl_i.start) begin
      quo_d  = mag_full[DW-1:0];
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      neg_d  = diff[DW];
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = QWidth'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[QWidth-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        acc_d  = quo_d;
        racc_d = rem_d;
      end
    end else if (ctrl_i.step) begin
      if (rsum >= {1'b0, divisor_i}) begin
        racc_d = QWidth'(rsum - {1'b0, divisor_i});
        acc_d  = acc_q + quo_q + 1'b1;
      end else begin
        racc_d = rsum[QWidth-1:0];
        acc_d  = acc_q + quo_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    racc_q <= racc_d;
    neg_q  <= neg_d;
  end

  // interpolated position, truncated toward zero by sign of difference
  assign offset = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign sum    = (DW+1)'(held_i) + offset;
  assign pos_o  = sum[PosWidth-1:0];
  assign busy_o = busy_q;

endmodule

/* rtl/core/pvt_segment_subdivider.sv */
// ----------------------------------------------------------------------------
// pvt_segment_subdivider
// holds one trajectory point and emits it with interpolated sub-points
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  in       | in_valid_i/in_ready_o, axis*_pos_i ...   | point in
//  out      | out_valid_o/out_ready_i, axis*_out_o ... | point out
//  cfg      | cfg_we_i, cfg_data_i                     | chunk time write
//
//  one point at a time: a held long segment passes from transfer to ready
//  through accept, an 8-step time divide, the held emit, a lane divide of
//  POS_WIDTH + 1 steps and one emit per interpolated point; short segments
//  skip the lane divide, and a final point adds its own emit
//  reset empties the held point and restores chunk time 20
//  a stalled output holds the sequencer at its current emit state
module pvt_segment_subdivider #(
  parameter int unsigned AXES      = pvtss_pkg::AxesDef,
  parameter int unsigned POS_WIDTH = pvtss_pkg::PosWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pvtss_pkg::TimeWidth-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [POS_WIDTH-1:0]       axis0_pos_i,
  input  logic signed [POS_WIDTH-1:0]       axis1_pos_i,
  input  logic signed [POS_WIDTH-1:0]       axis2_pos_i,
  input  logic [pvtss_pkg::TimeWidth-1:0]   seg_time_i,
  input  logic                              final_point_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [POS_WIDTH-1:0]       axis0_out_o,
  output logic signed [POS_WIDTH-1:0]       axis1_out_o,
  output logic signed [POS_WIDTH-1:0]       axis2_out_o,
  output logic [pvtss_pkg::TimeWidth-1:0]   out_time_o,
  output logic                              run_last_o
);
  import pvtss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TDIV = 6'b000010,
    S_HELD = 6'b000100,
    S_LDIV = 6'b001000,
    S_INT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [TimeWidth-1:0]        chunk_q, c_eff;
  logic signed [POS_WIDTH-1:0] in_pos [MaxAxes];
  logic signed [POS_WIDTH-1:0] new_q [MaxAxes];
  logic signed [POS_WIDTH-1:0] held_q [MaxAxes];
  logic signed [POS_WIDTH-1:0] lane_pos [MaxAxes];
  logic [MaxAxes-1:0]          lane_busy;
  logic [TimeWidth-1:0]        new_time_q, held_time_q;
  logic                        fin_q, held_valid_q;
  logic [TimeWidth-1:0]        trem_q, tquo_q;
  logic [TimeWidth:0]          ttrial;
  logic [3:0]                  tcnt_q;
  logic [QWidth-1:0]           q_val, t_q;
  lane_ctrl_t                  lane_ctrl;

  logic                        in_xfer, push, push_ok, last_int, store_new;
  logic signed [POS_WIDTH-1:0] push_pos [MaxAxes];
  logic [TimeWidth-1:0]        push_time;
  logic                        push_last;
  logic                        out_valid_q;
  logic signed [POS_WIDTH-1:0] out_pos_q [MaxAxes];
  logic [TimeWidth-1:0]        out_time_q;
  logic                        out_last_q;

  assign in_pos[0] = axis0_pos_i;
  assign in_pos[1] = axis1_pos_i;
  assign in_pos[2] = axis2_pos_i;

  // chunk time register, saturated below four on use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
    end else if (cfg_we_i) begin
      chunk_q <= cfg_data_i;
    end
  end
  assign c_eff = (chunk_q < ChunkMin) ? ChunkMin : chunk_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign push_ok    = !out_valid_q || out_ready_i;
  assign q_val      = tquo_q[QWidth-1:0];
  assign last_int   = (t_q == q_val - 1'b1);
  assign ttrial     = {trem_q, tquo_q[TimeWidth-1]};

  // axis lanes
  for (genvar a = 0; a < MaxAxes; a++) begin : g_lane
    if (a < AXES) begin : g_on
      pvtss_lane #(.PosWidth(POS_WIDTH)) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (lane_ctrl),
        .divisor_i(q_val),
        .held_i   (held_q[a]),
        .new_i    (new_q[a]),
        .pos_o    (lane_pos[a]),
        .busy_o   (lane_busy[a])
      );
    end else begin : g_off
      assign lane_pos[a]  = '0;
      assign lane_busy[a] = 1'b0;
    end
  end

  // sequencer and emit selection
  always_comb begin
    state_d         = state_q;
    push            = 1'b0;
    push_time       = c_eff;
    push_last       = 1'b0;
    lane_ctrl.start = 1'b0;
    lane_ctrl.step  = 1'b0;
    store_new       = 1'b0;
    for (int a = 0; a < MaxAxes; a++) push_pos[a] = held_q[a];
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (held_valid_q) state_d = S_TDIV;
          else if (final_point_i) state_d = S_FIN;
        end
      end
      S_TDIV: begin
        if (tcnt_q == 4'd7) state_d = S_HELD;
      end
      S_HELD: begin
        push      = 1'b1;
        push_time = out_time_of(held_time_q, c_eff);
        push_last = (q_val < QWidth'(2)) && !fin_q;
        if (push_ok) begin
          if (q_val >= QWidth'(2)) begin
            lane_ctrl.start = 1'b1;
            state_d         = S_LDIV;
          end else if (fin_q) begin
            state_d = S_FIN;
          end else begin
            store_new = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      S_LDIV: begin
        if (lane_busy == '0) state_d = S_INT;
      end
      S_INT: begin
        push      = 1'b1;
        push_last = last_int && !fin_q;
        for (int a = 0; a < MaxAxes; a++) push_pos[a] = lane_pos[a];
        if (push_ok) begin
          lane_ctrl.step = 1'b1;
          if (last_int) begin
            if (fin_q) begin
              state_d = S_FIN;
            end else begin
              store_new = 1'b1;
              state_d   = S_IDLE;
            end
          end
        end
      end
      S_FIN: begin
        push      = 1'b1;
        push_time = out_time_of(new_time_q, c_eff);
        push_last = 1'b1;
        for (int a = 0; a < MaxAxes; a++) push_pos[a] = new_q[a];
        if (push_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tcnt_q       <= '0;
      t_q          <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer && !held_valid_q) held_valid_q <= !final_point_i;
      else if (store_new) held_valid_q <= 1'b1;
      else if (state_q == S_FIN && push_ok) held_valid_q <= 1'b0;
      if (push && push_ok) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_xfer) tcnt_q <= '0;
      else if (state_q == S_TDIV) tcnt_q <= tcnt_q + 1'b1;
      if (state_q == S_LDIV) t_q <= QWidth'(1);
      else if (state_q == S_INT && push_ok) t_q <= t_q + 1'b1;
    end
  end

  // point storage and time divider
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int a = 0; a < MaxAxes; a++) begin
        new_q[a] <= (a < AXES) ? in_pos[a] : '0;
      end
      new_time_q <= seg_time_i;
      fin_q      <= final_point_i;
      trem_q     <= '0;
      tquo_q     <= held_time_q;
      if (!held_valid_q && !final_point_i) begin
        for (int a = 0; a < MaxAxes; a++) begin
          held_q[a] <= (a < AXES) ? in_pos[a] : '0;
        end
        held_time_q <= seg_time_i;
      end
    end else if (state_q == S_TDIV) begin
      if (ttrial >= {1'b0, c_eff}) begin
        trem_q <= TimeWidth'(ttrial - {1'b0, c_eff});
        tquo_q <= {tquo_q[TimeWidth-2:0], 1'b1};
      end else begin
        trem_q <= ttrial[TimeWidth-1:0];
        tquo_q <= {tquo_q[TimeWidth-2:0], 1'b0};
      end
    end
    if (store_new) begin
      held_q      <= new_q;
      held_time_q <= new_time_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (push && push_ok) begin
      out_pos_q  <= push_pos;
      out_time_q <= push_time;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis0_out_o = out_pos_q[0];
  assign axis1_out_o = out_pos_q[1];
  assign axis2_out_o = out_pos_q[2];
  assign out_time_o  = out_time_q;
  assign run_last_o  = out_last_q;

endmodule

/* tb/sv/tb_pvt_segment_subdivider.sv */
// ----------------------------------------------------------------------------
// tb_pvt_segment_subdivider
// Self-checking bench for the trajectory segment subdivider. Trajectory
// points are streamed through valid/ready with random sender gaps and
// receiver stalls. A behavioral subdivider predicts every emitted point,
// and each output transfer is checked field by field against it. The bench
// switches the chunk time between phases, including below the minimum and
// the largest value.
// ----------------------------------------------------------------------------
module tb_pvt_segment_subdivider;
  timeunit 1ns;
  timeprecision 1ps;

  import pvtss_pkg::*;

  localparam int unsigned PW        = 32;
  localparam int unsigned DrainWait = 200;
  localparam int unsigned StallMax  = 6000;

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  typedef struct {
    logic signed [PW-1:0] pos [3];
    logic [TimeWidth-1:0] seg;
    logic                 fin;
  } point_t;

  typedef struct {
    logic [PW-1:0]        pos [3];
    logic [TimeWidth-1:0] dur;
    logic                 last;
  } emit_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [TimeWidth-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [PW-1:0] axis0_pos_i, axis1_pos_i, axis2_pos_i;
  logic [TimeWidth-1:0] seg_time_i;
  logic                 final_point_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [PW-1:0] axis0_out_o, axis1_out_o, axis2_out_o;
  logic [TimeWidth-1:0] out_time_o;
  logic                 run_last_o;

  pvt_segment_subdivider u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .axis0_pos_i   (axis0_pos_i),
    .axis1_pos_i   (axis1_pos_i),
    .axis2_pos_i   (axis2_pos_i),
    .seg_time_i    (seg_time_i),
    .final_point_i (final_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .axis0_out_o   (axis0_out_o),
    .axis1_out_o   (axis1_out_o),
    .axis2_out_o   (axis2_out_o),
    .out_time_o    (out_time_o),
    .run_last_o    (run_last_o)
  );

  point_t     pending_points [$];
  emit_t      expected_emits [$];
  idle_mode_e idle_mode;
  bit         in_fire;
  int         error_count;
  int         points_sent;
  int         emits_checked;
  int         stall_cycles;

  // subdivider state mirrored by the predictor
  bit                   hold_valid;
  logic signed [PW-1:0] hold_pos [3];
  logic [TimeWidth-1:0] hold_seg;
  logic [TimeWidth-1:0] chunk_reg;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [TimeWidth-1:0] eff_chunk();
    return (chunk_reg < ChunkMin) ? ChunkMin : chunk_reg;
  endfunction

  function automatic logic [TimeWidth-1:0] shown_time(logic [TimeWidth-1:0] t);
    logic [TimeWidth-1:0] c;
    c = eff_chunk();
    return ((t == '0) || (t >= c)) ? c : t;
  endfunction

  // append one predicted point to the expected list
  task automatic add_emit(emit_t e);
    expected_emits.insert(expected_emits.size(), e);
  endtask

  // predict the emitted points caused by one accepted point
  task automatic subdivide_point(point_t p);
    emit_t   e;
    int      first_idx;
    longint  n, diff;
    int      c;
    first_idx = expected_emits.size();
    c = eff_chunk();
    if (hold_valid) begin
      for (int j = 0; j < 3; j++) e.pos[j] = hold_pos[j];
      e.dur  = shown_time(hold_seg);
      e.last = 1'b0;
      add_emit(e);
      if (hold_seg != '0 && hold_seg >= c) begin
        n = longint'(hold_seg / c) - 1;
        for (longint t = 1; t <= n; t++) begin
          for (int j = 0; j < 3; j++) begin
            diff = longint'(p.pos[j]) - longint'(hold_pos[j]);
            e.pos[j] = PW'(longint'(hold_pos[j]) + (diff * t) / (n + 1));
          end
          e.dur = c[TimeWidth-1:0];
          add_emit(e);
        end
      end
    end
    if (p.fin) begin
      for (int j = 0; j < 3; j++) e.pos[j] = p.pos[j];
      e.dur  = shown_time(p.seg);
      e.last = 1'b0;
      add_emit(e);
      hold_valid = 1'b0;
    end else begin
      for (int j = 0; j < 3; j++) hold_pos[j] = p.pos[j];
      hold_seg   = p.seg;
      hold_valid = 1'b1;
    end
    if (expected_emits.size() > first_idx)
      expected_emits[expected_emits.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // input driver, changes on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    point_t p;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      axis0_pos_i   <= '0;
      axis1_pos_i   <= '0;
      axis2_pos_i   <= '0;
      seg_time_i    <= '0;
      final_point_i <= 1'b0;
      out_ready_i   <= 1'b0;
    end else begin
      if ((!in_valid_i || in_fire) && pending_points.size() > 0 &&
          !((idle_mode == IdleSend && $urandom_range(99) < 65) ||
            (idle_mode == IdleBoth && $urandom_range(99) < 29))) begin
        p = pending_points.pop_front();
        in_valid_i    <= 1'b1;
        axis0_pos_i   <= p.pos[0];
        axis1_pos_i   <= p.pos[1];
        axis2_pos_i   <= p.pos[2];
        seg_time_i    <= p.seg;
        final_point_i <= p.fin;
      end else if (in_fire) begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= !((idle_mode == IdleRecv && $urandom_range(99) < 65) ||
                       (idle_mode == IdleBoth && $urandom_range(99) < 29));
    end
  end

  // monitor and scoreboard, sampled on the rising edge
  always @(posedge clk_i) begin
    emit_t e;
    in_fire = 1'b0;
    if (rst_ni) begin
      stall_cycles++;
      if (in_valid_i && in_ready_o) begin
        point_t p;
        p.pos[0] = axis0_pos_i;
        p.pos[1] = axis1_pos_i;
        p.pos[2] = axis2_pos_i;
        p.seg    = seg_time_i;
        p.fin    = final_point_i;
        subdivide_point(p);
        in_fire = 1'b1;
        points_sent++;
        stall_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        stall_cycles = 0;
        if (expected_emits.size() == 0) begin
          report_mismatch("unexpected transfer", axis0_out_o, '0);
        end else begin
          e = expected_emits.pop_front();
          emits_checked++;
          if (axis0_out_o !== e.pos[0]) report_mismatch("axis0", axis0_out_o, e.pos[0]);
          if (axis1_out_o !== e.pos[1]) report_mismatch("axis1", axis1_out_o, e.pos[1]);
          if (axis2_out_o !== e.pos[2]) report_mismatch("axis2", axis2_out_o, e.pos[2]);
          if (out_time_o !== e.dur) report_mismatch("out_time", PW'(out_time_o), PW'(e.dur));
          if (run_last_o !== e.last) report_mismatch("run_last", PW'(run_last_o), PW'(e.last));
        end
      end
      if (stall_cycles >= StallMax) begin
        $display("watchdog: no transfer in %0d cycles", StallMax);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_point(logic [PW-1:0] a0, logic [PW-1:0] a1, logic [PW-1:0] a2,
                             logic [TimeWidth-1:0] t, logic f);
    point_t p;
    p.pos[0] = a0;
    p.pos[1] = a1;
    p.pos[2] = a2;
    p.seg    = t;
    p.fin    = f;
    pending_points.insert(pending_points.size(), p);
  endtask

  function automatic logic [PW-1:0] rand_pos();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TimeWidth-1:0] rand_seg();
    int c;
    c = eff_chunk();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom_range(c - 1, 1);
      2: return TimeWidth'(c * $urandom_range(3, 1));
      3: return 8'd255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // mostly well-formed moves ending in a final point, some left open
  task automatic queue_random_moves(int count);
    int len;
    while (count > 0) begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len && count > 0; k++, count--)
        queue_point(rand_pos(), rand_pos(), rand_pos(), rand_seg(),
                    (k == len - 1) ? ($urandom_range(9) < 8) : ($urandom_range(19) == 0));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || in_valid_i || expected_emits.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_chunk(logic [TimeWidth-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    chunk_reg = v;
  endtask

  // stimulus sequencing
  initial begin
    logic [TimeWidth-1:0] chunk_plan [6];
    chunk_plan = '{8'd0, 8'd4, 8'd255, 8'd3, 8'd7, 8'd20};
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    idle_mode  = IdleNone;
    hold_valid = 1'b0;
    chunk_reg  = ChunkReset;
    rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, time zero, short, exact and long segments
    queue_point(32'h0000_0001, 32'hffff_ffff, 32'h1234_5678, 8'd5, 1'b1);
    queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd100, 1'b0);
    queue_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 8'd0, 1'b0);
    queue_point(32'h0001_0000, 32'h0, 32'h7fff_ffff, 8'd20, 1'b0);
    queue_point(32'hfffe_0000, 32'h0003_0000, 32'h8000_0000, 8'd19, 1'b0);
    queue_point(32'h0, 32'h0, 32'h0, 8'd255, 1'b0);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd41, 1'b0);
    queue_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd1, 1'b1);
    queue_point(32'hdead_beef, 32'h0, 32'h5555_5555, 8'd0, 1'b1);
    queue_point(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 8'd60, 1'b0);
    queue_point(32'h0, 32'h0, 32'h0, 8'd255, 1'b1);
    wait_drained();

    // random phases, each with a new chunk time and one of the idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_chunk(ph == 5 ? TimeWidth'($urandom_range(255, 4)) : chunk_plan[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      queue_random_moves(35);
      if (ph == 0) queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 8'd255, 1'b0);
      if (ph == 0) queue_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 8'd0, 1'b1);
      wait_drained();
    end

    $display("run covered %0d points and %0d checked output transfers", points_sent,
             emits_checked);
    $display("chunk times 0 to 255, sender gaps and receiver stalls in several phases");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
